/* hdl/cpcf_pkg.sv */
// ----------------------------------------------------------------------------
// cpcf_pkg
// Shared types and constants of the pair contact force pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package cpcf_pkg;

  // Depth of the pipelined square root, one root bit per stage.
  localparam int SQRT_STAGES = 32;
  // Depth of the pipelined divider, one quotient bit per stage.
  localparam int DIV_STAGES  = 48;

  // Gain register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_REPULSION = 3'd0,
    REG_TUMOR_ADH = 3'd1,
    REG_NORM_ADH  = 3'd2,
    REG_WALL_ADH  = 3'd3,
    REG_WALL_REP  = 3'd4
  } reg_idx_t;

  // Reset values of the gains, unsigned Q16.16.
  localparam logic [31:0] RST_REPULSION = 32'd65536;
  localparam logic [31:0] RST_TUMOR_ADH = 32'd65536;
  localparam logic [31:0] RST_NORM_ADH  = 32'd65536;
  localparam logic [31:0] RST_WALL_ADH  = 32'd6553600;
  localparam logic [31:0] RST_WALL_REP  = 32'd3203636;

  // Largest force magnitude, 2^31 LSB.
  localparam logic [63:0] MAG_LIMIT = 64'h0000_0000_8000_0000;

  // Displacement as sign and magnitude, plus mode bits.
  typedef struct packed {
    logic        cmd;
    logic        norm;
    logic        sx;
    logic        sy;
    logic [31:0] ax;
    logic [31:0] ay;
  } vec_t;

  // Item state ahead of the distance computation.
  typedef struct packed {
    vec_t        v;
    logic [30:0] ra;
    logic [30:0] rn;
    logic [30:0] rc;
    logic [30:0] d;
    logic        wsat;
  } early_t;

  // Item state once the distance is known.
  typedef struct packed {
    vec_t        v;
    logic [31:0] r;
    logic        zero;
    logic        in_ra;
    logic        in_nuc;
    logic        in_body;
    logic        body_nz;
    logic        wsat;
  } item_t;

  // Sign and special-case flags that ride along the final division.
  typedef struct packed {
    logic sx;
    logic sy;
    logic neg;
    logic zero;
    logic ax_nz;
    logic ay_nz;
  } proj_t;

endpackage

`default_nettype wire

/* hdl/cpcf_sqrt.sv */
// ----------------------------------------------------------------------------
// cpcf_sqrt
// Pipelined integer square root of a 64-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cpcf_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rad,
  output logic [31:0] root
);

  localparam int N = cpcf_pkg::SQRT_STAGES;

  logic [33:0] rem_r   [N];
  logic [63:0] rad_r   [N];
  logic [31:0] root_r  [N];
  logic [33:0] rem_nxt [N];
  logic [63:0] rad_nxt [N];
  logic [31:0] root_nxt[N];

  // Each stage brings down two radicand bits and tries the next root bit.
  always_comb begin
    logic [33:0] rem_in;
    logic [63:0] rad_in;
    logic [31:0] root_in;
    logic [35:0] sh;
    logic [35:0] trial;
    logic        take;
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        rem_in  = '0;
        rad_in  = rad;
        root_in = '0;
      end else begin
        rem_in  = rem_r[k-1];
        rad_in  = rad_r[k-1];
        root_in = root_r[k-1];
      end
      sh          = {rem_in, rad_in[63:62]};
      trial       = {2'b00, root_in, 2'b01};
      take        = (sh >= trial);
      rem_nxt[k]  = take ? 34'(sh - trial) : sh[33:0];
      rad_nxt[k]  = {rad_in[61:0], 2'b00};
      root_nxt[k] = {root_in[30:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        rem_r[k]  <= rem_nxt[k];
        rad_r[k]  <= rad_nxt[k];
        root_r[k] <= root_nxt[k];
      end
    end
  end

  assign root = root_r[N-1];

endmodule

`default_nettype wire

/* hdl/cpcf_div.sv */
// ----------------------------------------------------------------------------
// cpcf_div
// Pipelined restoring divider: the dividend is a 32-bit partial remainder
// followed by 48 more bits, and one quotient bit is formed per stage.
// The partial remainder must be below the divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module cpcf_div (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] num_hi,
  input  logic [47:0] num_lo,
  input  logic [31:0] den,
  output logic [47:0] quo
);

  localparam int N = cpcf_pkg::DIV_STAGES;

  logic [31:0] rem_r   [N];
  logic [47:0] tail_r  [N];
  logic [31:0] den_r   [N];
  logic [47:0] q_r     [N];
  logic [31:0] rem_nxt [N];
  logic [47:0] tail_nxt[N];
  logic [31:0] den_nxt [N];
  logic [47:0] q_nxt   [N];

  // Shift in the next dividend bit and subtract the divisor when it fits.
  always_comb begin
    logic [31:0] rem_in;
    logic [47:0] tail_in;
    logic [31:0] den_in;
    logic [47:0] q_in;
    logic [32:0] sh;
    logic        take;
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        rem_in  = num_hi;
        tail_in = num_lo;
        den_in  = den;
        q_in    = '0;
      end else begin
        rem_in  = rem_r[k-1];
        tail_in = tail_r[k-1];
        den_in  = den_r[k-1];
        q_in    = q_r[k-1];
      end
      sh          = {rem_in, tail_in[47]};
      take        = (sh >= {1'b0, den_in});
      rem_nxt[k]  = take ? 32'(sh - {1'b0, den_in}) : sh[31:0];
      tail_nxt[k] = {tail_in[46:0], 1'b0};
      den_nxt[k]  = den_in;
      q_nxt[k]    = {q_in[46:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        rem_r[k]  <= rem_nxt[k];
        tail_r[k] <= tail_nxt[k];
        den_r[k]  <= den_nxt[k];
        q_r[k]    <= q_nxt[k];
      end
    end
  end

  assign quo = q_r[N-1];

endmodule

`default_nettype wire

/* hdl/cell_pair_contact_force_core.sv */
// ----------------------------------------------------------------------------
// cell_pair_contact_force_core
// Adhesion and repulsion force between two cells, or a cell and a wall.
//
// Input beats carry a displacement and three radii; each gives exactly one
// output beat with the saturated force on the first body and a flag for
// zero distance. Gains are to be written on the cfg channel (always ready)
// only while the pipeline holds no item; the block does not enforce this.
//
// Throughput is one beat per cycle unless out_tready stalls the pipeline.
// From the input beat to out_tvalid an item passes 4 front stages, a
// 32-stage square root, a register, 48 stages for the radius ratios, 9
// arithmetic stages, 48 stages for the projection onto the axes and the
// output register; the two divider chains and the root are the deepest.
//
// The whole pipeline advances together. When out_tvalid is high and
// out_tready low, every stage holds and in_tready drops, so nothing is lost
// or repeated. Reset clears the valid bits and loads the default gains.
// ----------------------------------------------------------------------------
`default_nettype none

module cell_pair_contact_force_core (
  input  logic         clk,
  input  logic         rst_n,
  // Input stream.
  input  logic         in_tvalid,
  output logic         in_tready,
  // [31:0] disp_x, [63:32] disp_y, [94:64] reach_radius,
  // [125:95] core_radius, [156:126] body_radius, [157] normoxic_pair
  input  logic [159:0] in_tdata,
  // [0] command
  input  logic         in_tuser,
  // Result stream.
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] force_x, [63:32] force_y
  output logic [63:0]  out_tdata,
  // [0] zero_distance
  output logic         out_tuser,
  // Gain register writes.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int NSQ = cpcf_pkg::SQRT_STAGES;
  localparam int NDV = cpcf_pkg::DIV_STAGES;

  logic adv;

  // Gain registers.
  logic [31:0] rep_gain_r;
  logic [31:0] tumor_adh_r;
  logic [31:0] norm_adh_r;
  logic [31:0] wall_adh_r;
  logic [31:0] wall_rep_r;

  // Output register.
  logic        out_valid_r;
  logic [31:0] out_fx_r;
  logic [31:0] out_fy_r;
  logic        out_zero_r;

  assign adv        = !out_valid_r || out_tready;
  assign in_tready  = adv;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_fy_r, out_fx_r};
  assign out_tuser  = out_zero_r;

  // Gain register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_gain_r  <= cpcf_pkg::RST_REPULSION;
      tumor_adh_r <= cpcf_pkg::RST_TUMOR_ADH;
      norm_adh_r  <= cpcf_pkg::RST_NORM_ADH;
      wall_adh_r  <= cpcf_pkg::RST_WALL_ADH;
      wall_rep_r  <= cpcf_pkg::RST_WALL_REP;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cpcf_pkg::REG_REPULSION: rep_gain_r  <= cfg_data;
        cpcf_pkg::REG_TUMOR_ADH: tumor_adh_r <= cfg_data;
        cpcf_pkg::REG_NORM_ADH:  norm_adh_r  <= cfg_data;
        cpcf_pkg::REG_WALL_ADH:  wall_adh_r  <= cfg_data;
        cpcf_pkg::REG_WALL_REP:  wall_rep_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Front stages: capture, sign split, squares and their sum.
  // --------------------------------------------------------------------------
  logic        s0_vld_r;
  logic        s0_cmd_r;
  logic        s0_norm_r;
  logic [31:0] s0_x_r;
  logic [31:0] s0_y_r;
  logic [30:0] s0_ra_r;
  logic [30:0] s0_rn_r;
  logic [30:0] s0_rc_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_cmd_r  <= in_tuser;
      s0_x_r    <= in_tdata[31:0];
      s0_y_r    <= in_tdata[63:32];
      s0_ra_r   <= in_tdata[94:64];
      s0_rn_r   <= in_tdata[125:95];
      s0_rc_r   <= in_tdata[156:126];
      s0_norm_r <= in_tdata[157];
    end
  end

  cpcf_pkg::early_t s1_nxt;
  cpcf_pkg::early_t s1_e_r;
  logic             s1_vld_r;

  // Magnitudes of the components and the nucleus-to-body difference.
  always_comb begin
    s1_nxt.v.cmd  = s0_cmd_r;
    s1_nxt.v.norm = s0_norm_r;
    s1_nxt.v.sx   = s0_x_r[31];
    s1_nxt.v.sy   = s0_y_r[31];
    s1_nxt.v.ax   = s0_x_r[31] ? 32'(-s0_x_r) : s0_x_r;
    s1_nxt.v.ay   = s0_y_r[31] ? 32'(-s0_y_r) : s0_y_r;
    s1_nxt.ra     = s0_ra_r;
    s1_nxt.rn     = s0_rn_r;
    s1_nxt.rc     = s0_rc_r;
    s1_nxt.d      = (s0_rc_r > s0_rn_r) ? 31'(s0_rc_r - s0_rn_r)
                                        : 31'(s0_rn_r - s0_rc_r);
    // The ratio saturates its square once it reaches 2^16.
    s1_nxt.wsat   = ({16'd0, s1_nxt.d} >= {s0_rc_r, 16'd0});
  end

  logic             s2_vld_r;
  cpcf_pkg::early_t s2_e_r;
  logic [63:0]      s2_xx_r;
  logic [63:0]      s2_yy_r;
  logic             s3_vld_r;
  cpcf_pkg::early_t s3_e_r;
  logic [63:0]      s3_sum_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_e_r   <= s1_nxt;
      s2_e_r   <= s1_e_r;
      s2_xx_r  <= 64'(s1_e_r.v.ax) * 64'(s1_e_r.v.ax);
      s2_yy_r  <= 64'(s1_e_r.v.ay) * 64'(s1_e_r.v.ay);
      s3_e_r   <= s2_e_r;
      s3_sum_r <= s2_xx_r + s2_yy_r;
    end
  end

  // --------------------------------------------------------------------------
  // Distance: pipelined square root with the item riding alongside.
  // --------------------------------------------------------------------------
  logic [31:0]      sq_root;
  cpcf_pkg::early_t sq_side_r [NSQ];
  logic             sq_vld_r  [NSQ];

  cpcf_sqrt u_sqrt (
    .clk  (clk),
    .en   (adv),
    .rad  (s3_sum_r),
    .root (sq_root)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_side_r[0] <= s3_e_r;
      for (int k = 1; k < NSQ; k++) begin
        sq_side_r[k] <= sq_side_r[k-1];
      end
    end
  end

  // Region flags against the three radii.
  cpcf_pkg::early_t s4_src;
  cpcf_pkg::item_t  s4_nxt;
  logic             s4_vld_r;
  cpcf_pkg::item_t  s4_item_r;
  logic [30:0]      s4_ra_r;
  logic [30:0]      s4_rn_r;
  logic [30:0]      s4_rc_r;
  logic [30:0]      s4_d_r;

  always_comb begin
    s4_src         = sq_side_r[NSQ-1];
    s4_nxt.v       = s4_src.v;
    s4_nxt.r       = sq_root;
    s4_nxt.zero    = (sq_root == 32'd0);
    s4_nxt.in_ra   = (sq_root <= {1'b0, s4_src.ra});
    s4_nxt.in_nuc  = (sq_root <  {1'b0, s4_src.rn});
    s4_nxt.in_body = (sq_root <= {1'b0, s4_src.rc});
    s4_nxt.body_nz = (s4_src.rc != 31'd0);
    s4_nxt.wsat    = s4_src.wsat;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_item_r <= s4_nxt;
      s4_ra_r   <= s4_src.ra;
      s4_rn_r   <= s4_src.rn;
      s4_rc_r   <= s4_src.rc;
      s4_d_r    <= s4_src.d;
    end
  end

  // --------------------------------------------------------------------------
  // Ratios r/ra, r/rn, r/rc and d/rc as unsigned Q16.32 quotients.
  // --------------------------------------------------------------------------
  logic [47:0]     q_fa;
  logic [47:0]     q_fn;
  logic [47:0]     q_fc;
  logic [47:0]     q_fw;
  cpcf_pkg::item_t dv_item_r [NDV];
  logic            dv_vld_r  [NDV];

  cpcf_div u_div_ra (
    .clk    (clk),
    .en     (adv),
    .num_hi ({16'd0, s4_item_r.r[31:16]}),
    .num_lo ({s4_item_r.r[15:0], 32'd0}),
    .den    ({1'b0, s4_ra_r}),
    .quo    (q_fa)
  );

  cpcf_div u_div_rn (
    .clk    (clk),
    .en     (adv),
    .num_hi ({16'd0, s4_item_r.r[31:16]}),
    .num_lo ({s4_item_r.r[15:0], 32'd0}),
    .den    ({1'b0, s4_rn_r}),
    .quo    (q_fn)
  );

  cpcf_div u_div_rc (
    .clk    (clk),
    .en     (adv),
    .num_hi ({16'd0, s4_item_r.r[31:16]}),
    .num_lo ({s4_item_r.r[15:0], 32'd0}),
    .den    ({1'b0, s4_rc_r}),
    .quo    (q_fc)
  );

  cpcf_div u_div_w (
    .clk    (clk),
    .en     (adv),
    .num_hi ({17'd0, s4_d_r[30:16]}),
    .num_lo ({s4_d_r[15:0], 32'd0}),
    .den    ({1'b0, s4_rc_r}),
    .quo    (q_fw)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_item_r[0] <= s4_item_r;
      for (int k = 1; k < NDV; k++) begin
        dv_item_r[k] <= dv_item_r[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Polynomial terms and gains.
  // --------------------------------------------------------------------------
  logic [31:0] om_a;
  logic [31:0] om_c;

  // One minus a ratio; the ratio lies in (0, 1] wherever it is used.
  assign om_a = 32'(-q_fa[31:0]);
  assign om_c = 32'(-q_fc[31:0]);

  // E1: squares and partial products of w^2.
  logic            e1_vld_r;
  cpcf_pkg::item_t e1_item_r;
  logic [63:0]     e1_sa_r;
  logic [63:0]     e1_sc_r;
  logic [63:0]     e1_wll_r;
  logic [47:0]     e1_whl_r;
  logic [31:0]     e1_whh_r;
  logic [31:0]     e1_g_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_item_r <= dv_item_r[NDV-1];
      e1_sa_r   <= 64'(om_a) * 64'(om_a);
      e1_sc_r   <= 64'(om_c) * 64'(om_c);
      e1_wll_r  <= 64'(q_fw[31:0]) * 64'(q_fw[31:0]);
      e1_whl_r  <= 48'(q_fw[47:32]) * 48'(q_fw[31:0]);
      e1_whh_r  <= 32'(q_fw[47:32]) * 32'(q_fw[47:32]);
      e1_g_r    <= q_fn[31:0];
    end
  end

  // E2: adhesion and outer repulsion shapes, w^2 in Q32.32.
  logic            e2_vld_r;
  cpcf_pkg::item_t e2_item_r;
  logic [31:0]     e2_a_r;
  logic [31:0]     e2_pq_r;
  logic [63:0]     e2_w2_r;
  logic [32:0]     e2_base_r;
  logic [31:0]     e2_g_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      e2_item_r <= e1_item_r;
      e2_a_r    <= e1_sa_r[63:32];
      e2_pq_r   <= e1_sc_r[63:32];
      e2_w2_r   <= e1_item_r.wsat ? '1
                 : ({e1_whh_r, 32'd0} + {15'd0, e1_whl_r, 1'b0}
                    + {32'd0, e1_wll_r[63:32]});
      e2_base_r <= 33'h1_0000_0000 - {1'b0, e1_g_r};
      e2_g_r    <= e1_g_r;
    end
  end

  // E3: partial products of w^2 * g.
  logic            e3_vld_r;
  cpcf_pkg::item_t e3_item_r;
  logic [31:0]     e3_a_r;
  logic [31:0]     e3_pq_r;
  logic [32:0]     e3_base_r;
  logic [63:0]     e3_ph_r;
  logic [63:0]     e3_pl_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      e3_item_r <= e2_item_r;
      e3_a_r    <= e2_a_r;
      e3_pq_r   <= e2_pq_r;
      e3_base_r <= e2_base_r;
      e3_ph_r   <= 64'(e2_w2_r[63:32]) * 64'(e2_g_r);
      e3_pl_r   <= 64'(e2_w2_r[31:0]) * 64'(e2_g_r);
    end
  end

  // E4: w^2 * g, wrapping at 64 bits.
  logic            e4_vld_r;
  cpcf_pkg::item_t e4_item_r;
  logic [31:0]     e4_a_r;
  logic [31:0]     e4_pq_r;
  logic [32:0]     e4_base_r;
  logic [63:0]     e4_term_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      e4_item_r <= e3_item_r;
      e4_a_r    <= e3_a_r;
      e4_pq_r   <= e3_pq_r;
      e4_base_r <= e3_base_r;
      e4_term_r <= e3_ph_r + {32'd0, e3_pl_r[63:32]};
    end
  end

  // E5: pick the repulsion shape by region, the adhesion by reach, and gains.
  logic [64:0] pn_sum;
  logic [63:0] pn;
  logic [63:0] e5_p_nxt;

  assign pn_sum = {32'd0, e4_base_r} + {1'b0, e4_term_r};
  assign pn     = pn_sum[64] ? '1 : pn_sum[63:0];

  always_comb begin
    if (e4_item_r.in_nuc) begin
      e5_p_nxt = e4_item_r.body_nz ? pn : 64'd0;
    end else if (e4_item_r.in_body) begin
      e5_p_nxt = {32'd0, e4_pq_r};
    end else begin
      e5_p_nxt = 64'd0;
    end
  end

  logic            e5_vld_r;
  cpcf_pkg::item_t e5_item_r;
  logic [63:0]     e5_p_r;
  logic [31:0]     e5_a_r;
  logic [31:0]     e5_gr_r;
  logic [31:0]     e5_ga_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      e5_item_r <= e4_item_r;
      e5_p_r    <= e5_p_nxt;
      e5_a_r    <= e4_item_r.in_ra ? e4_a_r : 32'd0;
      e5_gr_r   <= e4_item_r.v.cmd ? wall_rep_r : rep_gain_r;
      e5_ga_r   <= e4_item_r.v.cmd  ? wall_adh_r
                 : e4_item_r.v.norm ? norm_adh_r : tumor_adh_r;
    end
  end

  // E6: gain products.
  logic            e6_vld_r;
  cpcf_pkg::item_t e6_item_r;
  logic [63:0]     e6_mh_r;
  logic [63:0]     e6_ml_r;
  logic [63:0]     e6_ad_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      e6_item_r <= e5_item_r;
      e6_mh_r   <= 64'(e5_p_r[63:32]) * 64'(e5_gr_r);
      e6_ml_r   <= 64'(e5_p_r[31:0]) * 64'(e5_gr_r);
      e6_ad_r   <= 64'(e5_a_r) * 64'(e5_ga_r);
    end
  end

  // E7: repulsion magnitude in Q48.16 and adhesion magnitude in Q16.16.
  logic            e7_vld_r;
  cpcf_pkg::item_t e7_item_r;
  logic [63:0]     e7_mrep_r;
  logic [31:0]     e7_madh_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      e7_item_r <= e6_item_r;
      e7_mrep_r <= e6_mh_r + {32'd0, e6_ml_r[63:32]};
      e7_madh_r <= e6_ad_r[63:32];
    end
  end

  // E8: signed net magnitude, clamped to 2^31.
  logic        e8_neg_nxt;
  logic [63:0] e8_diff;

  assign e8_neg_nxt = (e7_mrep_r < {32'd0, e7_madh_r});
  assign e8_diff    = e8_neg_nxt ? ({32'd0, e7_madh_r} - e7_mrep_r)
                                 : (e7_mrep_r - {32'd0, e7_madh_r});

  logic            e8_vld_r;
  cpcf_pkg::item_t e8_item_r;
  logic            e8_neg_r;
  logic [31:0]     e8_mag_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      e8_item_r <= e7_item_r;
      e8_neg_r  <= e8_neg_nxt;
      e8_mag_r  <= (e8_diff > cpcf_pkg::MAG_LIMIT) ? cpcf_pkg::MAG_LIMIT[31:0]
                                                   : e8_diff[31:0];
    end
  end

  // E9: magnitude times each component, ahead of the divide by r.
  logic          e9_vld_r;
  cpcf_pkg::proj_t e9_flags_r;
  logic [31:0]   e9_r_r;
  logic [63:0]   e9_nx_r;
  logic [63:0]   e9_ny_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      e9_flags_r.sx    <= e8_item_r.v.sx;
      e9_flags_r.sy    <= e8_item_r.v.sy;
      e9_flags_r.neg   <= e8_neg_r;
      e9_flags_r.zero  <= e8_item_r.zero;
      e9_flags_r.ax_nz <= (e8_item_r.v.ax != 32'd0);
      e9_flags_r.ay_nz <= (e8_item_r.v.ay != 32'd0);
      e9_r_r           <= e8_item_r.r;
      e9_nx_r          <= 64'(e8_mag_r) * 64'(e8_item_r.v.ax);
      e9_ny_r          <= 64'(e8_mag_r) * 64'(e8_item_r.v.ay);
    end
  end

  // --------------------------------------------------------------------------
  // Projection onto the axes: |M| * |d_c| / r.
  // --------------------------------------------------------------------------
  logic [47:0]     q_cx;
  logic [47:0]     q_cy;
  cpcf_pkg::proj_t pj_side_r [NDV];
  logic            pj_vld_r  [NDV];

  cpcf_div u_div_px (
    .clk    (clk),
    .en     (adv),
    .num_hi ({16'd0, e9_nx_r[63:48]}),
    .num_lo (e9_nx_r[47:0]),
    .den    (e9_r_r),
    .quo    (q_cx)
  );

  cpcf_div u_div_py (
    .clk    (clk),
    .en     (adv),
    .num_hi ({16'd0, e9_ny_r[63:48]}),
    .num_lo (e9_ny_r[47:0]),
    .den    (e9_r_r),
    .quo    (q_cy)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      pj_side_r[0] <= e9_flags_r;
      for (int k = 1; k < NDV; k++) begin
        pj_side_r[k] <= pj_side_r[k-1];
      end
    end
  end

  // Apply the sign and saturate each component.
  cpcf_pkg::proj_t pj_out;
  logic [31:0]     fx_nxt;
  logic [31:0]     fy_nxt;

  always_comb begin
    pj_out = pj_side_r[NDV-1];
    if (pj_out.zero || !pj_out.ax_nz) begin
      fx_nxt = 32'd0;
    end else if (pj_out.neg != pj_out.sx) begin
      fx_nxt = 32'(-q_cx[31:0]);
    end else begin
      fx_nxt = (q_cx > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : q_cx[31:0];
    end
    if (pj_out.zero || !pj_out.ay_nz) begin
      fy_nxt = 32'd0;
    end else if (pj_out.neg != pj_out.sy) begin
      fy_nxt = 32'(-q_cy[31:0]);
    end else begin
      fy_nxt = (q_cy > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : q_cy[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_fx_r   <= fx_nxt;
      out_fy_r   <= fy_nxt;
      out_zero_r <= pj_out.zero;
    end
  end

  // --------------------------------------------------------------------------
  // Valid bits, advancing with the data.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r    <= 1'b0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      s4_vld_r    <= 1'b0;
      e1_vld_r    <= 1'b0;
      e2_vld_r    <= 1'b0;
      e3_vld_r    <= 1'b0;
      e4_vld_r    <= 1'b0;
      e5_vld_r    <= 1'b0;
      e6_vld_r    <= 1'b0;
      e7_vld_r    <= 1'b0;
      e8_vld_r    <= 1'b0;
      e9_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < NSQ; k++) begin
        sq_vld_r[k] <= 1'b0;
      end
      for (int k = 0; k < NDV; k++) begin
        dv_vld_r[k] <= 1'b0;
        pj_vld_r[k] <= 1'b0;
      end
    end else if (adv) begin
      s0_vld_r    <= in_tvalid;
      s1_vld_r    <= s0_vld_r;
      s2_vld_r    <= s1_vld_r;
      s3_vld_r    <= s2_vld_r;
      sq_vld_r[0] <= s3_vld_r;
      for (int k = 1; k < NSQ; k++) begin
        sq_vld_r[k] <= sq_vld_r[k-1];
      end
      s4_vld_r    <= sq_vld_r[NSQ-1];
      dv_vld_r[0] <= s4_vld_r;
      for (int k = 1; k < NDV; k++) begin
        dv_vld_r[k] <= dv_vld_r[k-1];
      end
      e1_vld_r    <= dv_vld_r[NDV-1];
      e2_vld_r    <= e1_vld_r;
      e3_vld_r    <= e2_vld_r;
      e4_vld_r    <= e3_vld_r;
      e5_vld_r    <= e4_vld_r;
      e6_vld_r    <= e5_vld_r;
      e7_vld_r    <= e6_vld_r;
      e8_vld_r    <= e7_vld_r;
      e9_vld_r    <= e8_vld_r;
      pj_vld_r[0] <= e9_vld_r;
      for (int k = 1; k < NDV; k++) begin
        pj_vld_r[k] <= pj_vld_r[k-1];
      end
      out_valid_r <= pj_vld_r[NDV-1];
    end
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // A zero-distance result carries no force.
  ap_zero_force: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 64'd0)
    else $error("zero-distance beat with nonzero force");

  // The root is zero exactly when the displacement is zero.
  ap_root_zero: assert property (@(posedge clk) disable iff (!rst_n)
    s4_vld_r |-> (s4_item_r.zero ==
                  (s4_item_r.v.ax == 32'd0 && s4_item_r.v.ay == 32'd0)))
    else $error("distance zero flag disagrees with displacement");

  // The root is never below either component magnitude.
  ap_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s4_vld_r |-> (s4_item_r.r >= s4_item_r.v.ax && s4_item_r.r >= s4_item_r.v.ay))
    else $error("distance below a component magnitude");

  // The net magnitude respects its clamp.
  ap_mag_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    e8_vld_r |-> e8_mag_r <= cpcf_pkg::MAG_LIMIT[31:0])
    else $error("force magnitude above clamp");

  // A projected component never exceeds the magnitude bound.
  ap_proj_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pj_vld_r[NDV-1] && !pj_side_r[NDV-1].zero |->
      (q_cx <= 48'h0000_8000_0000 && q_cy <= 48'h0000_8000_0000))
    else $error("projected component above magnitude bound");

endmodule

`default_nettype wire
